// ----- hw/rtl/nrmc_pkg.sv -----
// Shared types, character codes and helper functions for the NMEA RMC time extractor.
// Used by nrmc_time_fmt and nmea_rmc_time_extractor; depends on nothing else.
`default_nettype none

package nrmc_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned ZoneW    = 5;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned DigitsW  = 24;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned HdrLen   = 6;

  localparam logic [ZoneW-1:0] ZoneReset = 5'd8;

  localparam logic [CharW-1:0] ChDollar = 8'h24;
  localparam logic [CharW-1:0] ChStar   = 8'h2A;
  localparam logic [CharW-1:0] ChComma  = 8'h2C;
  localparam logic [CharW-1:0] ChFixA   = 8'h41;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BODY = 4'b0010,
    PH_CK1  = 4'b0100,
    PH_CK2  = 4'b1000
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_VALID   = 2'd0,
    ST_NOFIX   = 2'd1,
    ST_BADSUM  = 2'd2,
    ST_NOTRMC  = 2'd3
  } status_t;

  typedef struct packed {
    logic       is_rmc;
    logic       sum_good;
    logic       fix_ok;
  } sent_flags_t;

  typedef struct packed {
    status_t              status;
    logic [HourW-1:0]     hour;
    logic [MinW-1:0]      minute;
    logic [SecW-1:0]      second;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [CharW-1:0] hdr_char(input logic [2:0] idx);
    logic [CharW-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h47;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h52;
      3'd3:    ch = 8'h4D;
      3'd4:    ch = 8'h43;
      default: ch = ChComma;
    endcase
    return ch;
  endfunction

  function automatic hex_t hex_decode(input logic [CharW-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/nrmc_time_fmt.sv -----
// Result formatter: status priority, local hour with modulo-24 wrap, minute/second clamp.
// Depends on nrmc_pkg.
`default_nettype none

module nrmc_time_fmt (
  input  wire logic [nrmc_pkg::DigitsW-1:0] digits,
  input  wire logic [nrmc_pkg::ZoneW-1:0]   zone,
  input  wire nrmc_pkg::sent_flags_t        flags,
  output nrmc_pkg::result_t                 res
);

  logic [3:0] d0, d1, d2, d3, d4, d5;
  logic [7:0] hour_sum, h_a, h_b, h_c;
  logic [6:0] min_val, sec_val;

  assign d0 = digits[3:0];
  assign d1 = digits[7:4];
  assign d2 = digits[11:8];
  assign d3 = digits[15:12];
  assign d4 = digits[19:16];
  assign d5 = digits[23:20];

  always_comb begin
    hour_sum = {1'b0, d0, 3'b000} + {3'b000, d0, 1'b0} + {4'd0, d1} + {3'd0, zone};
    h_a = (hour_sum >= 8'd96) ? hour_sum - 8'd96 : hour_sum;
    h_b = (h_a >= 8'd48) ? h_a - 8'd48 : h_a;
    h_c = (h_b >= 8'd24) ? h_b - 8'd24 : h_b;
    min_val = {d2, 3'b000} + {2'b00, d2, 1'b0} + {3'd0, d3};
    sec_val = {d4, 3'b000} + {2'b00, d4, 1'b0} + {3'd0, d5};

    res.hour   = '0;
    res.minute = '0;
    res.second = '0;
    if (!flags.is_rmc) begin
      res.status = nrmc_pkg::ST_NOTRMC;
    end else if (!flags.sum_good) begin
      res.status = nrmc_pkg::ST_BADSUM;
    end else if (!flags.fix_ok) begin
      res.status = nrmc_pkg::ST_NOFIX;
    end else begin
      res.status = nrmc_pkg::ST_VALID;
      res.hour   = h_c[nrmc_pkg::HourW-1:0];
      res.minute = (min_val > 7'd59) ? 6'd59 : min_val[nrmc_pkg::MinW-1:0];
      res.second = (sec_val > 7'd59) ? 6'd59 : sec_val[nrmc_pkg::SecW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nmea_rmc_time_extractor.sv -----
// NMEA 0183 RMC sentence parser top level: input register, per-character parser, result register.
// Depends on nrmc_pkg and nrmc_time_fmt.
//
// Usage:
//   in_*  : one received ASCII character per transaction (in_tdata[7:0]).
//   out_* : one result per completed sentence, after the second checksum digit
//           or an invalid checksum digit. Nothing is emitted for other characters.
//   cfg_* : cfg_we writes the zone offset in hours (cfg_wdata[4:0]); write it only
//           while no characters are in flight.
//   Path: the last character is held in the input register, then the parser result
//   is loaded into the result register, which drives out_tvalid.
//   Throughput: one character per cycle while no result waits on out_tready; the parser
//   state update is a single compare/XOR/latch step between the input and result registers.
//   Reset: rst_n low clears the parser to idle (waiting for '$'), empties both
//   registers and loads a zone offset of 8.
//   Stall: while a result waits on out_tready, the input register holds one
//   character and in_tready drops once it is full; nothing is lost.
`default_nettype none

module nmea_rmc_time_extractor (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [nrmc_pkg::CharW-1:0]    in_tdata,   // [7:0] char_in
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [nrmc_pkg::OutDataW-1:0]      out_tdata,  // [1:0] sentence_status,
                                                         // [6:2] local_hour,
                                                         // [12:7] minute_out,
                                                         // [18:13] second_out
  input  wire logic                          cfg_we,
  input  wire logic [nrmc_pkg::ZoneW-1:0]    cfg_wdata   // [4:0] zone_offset_hours
);

  logic                          in_vld_r;
  logic [nrmc_pkg::CharW-1:0]    in_char_r;
  logic [nrmc_pkg::ZoneW-1:0]    zone_r;

  nrmc_pkg::phase_t              phase_r, phase_nxt;
  logic [2:0]                    hdr_idx_r, hdr_idx_nxt;
  logic                          hdr_ok_r, hdr_ok_nxt;
  logic [7:0]                    xor_r, xor_nxt;
  logic [3:0]                    comma_r, comma_nxt;
  logic [2:0]                    fidx_r, fidx_nxt;
  logic                          fix_r, fix_nxt;
  logic [nrmc_pkg::DigitsW-1:0]  digits_r, digits_nxt;
  logic [3:0]                    ckhi_r, ckhi_nxt;

  logic                          out_vld_r;
  nrmc_pkg::result_t             res_r;
  nrmc_pkg::result_t             res_nxt;

  logic                          adv, fire, emit, sum_good;
  logic [3:0]                    dig;
  nrmc_pkg::hex_t                hx;
  nrmc_pkg::sent_flags_t         flags;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;
  assign fire      = in_vld_r && adv;

  assign hx  = nrmc_pkg::hex_decode(in_char_r);
  assign dig = (in_char_r >= 8'h30 && in_char_r <= 8'h39) ? in_char_r[3:0] : 4'd0;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    hdr_ok_nxt  = hdr_ok_r;
    xor_nxt     = xor_r;
    comma_nxt   = comma_r;
    fidx_nxt    = fidx_r;
    fix_nxt     = fix_r;
    digits_nxt  = digits_r;
    ckhi_nxt    = ckhi_r;
    emit        = 1'b0;
    sum_good    = 1'b0;

    if (in_char_r == nrmc_pkg::ChDollar) begin
      phase_nxt   = nrmc_pkg::PH_BODY;
      hdr_idx_nxt = 3'd0;
      hdr_ok_nxt  = 1'b1;
      xor_nxt     = 8'd0;
      comma_nxt   = 4'd0;
      fidx_nxt    = 3'd0;
      fix_nxt     = 1'b0;
      digits_nxt  = '0;
      ckhi_nxt    = 4'd0;
    end else begin
      case (phase_r)
        nrmc_pkg::PH_BODY: begin
          if (in_char_r == nrmc_pkg::ChStar) begin
            phase_nxt = nrmc_pkg::PH_CK1;
          end else begin
            xor_nxt = xor_r ^ in_char_r;
            if (hdr_idx_r < 3'(nrmc_pkg::HdrLen)) begin
              if (in_char_r != nrmc_pkg::hdr_char(hdr_idx_r)) hdr_ok_nxt = 1'b0;
              hdr_idx_nxt = hdr_idx_r + 3'd1;
            end
            if (in_char_r == nrmc_pkg::ChComma) begin
              if (comma_r != 4'd15) comma_nxt = comma_r + 4'd1;
              fidx_nxt = 3'd0;
            end else begin
              if (comma_r == 4'd1 && fidx_r < 3'd6) begin
                for (int k = 0; k < 6; k++) begin
                  if (fidx_r == 3'(k)) digits_nxt[4*k +: 4] = digits_r[4*k +: 4] | dig;
                end
              end else if (comma_r == 4'd2) begin
                fix_nxt = (fidx_r == 3'd0) && (in_char_r == nrmc_pkg::ChFixA);
              end
              if (fidx_r != 3'd7) fidx_nxt = fidx_r + 3'd1;
            end
          end
        end
        nrmc_pkg::PH_CK1: begin
          if (!hx.ok) begin
            emit      = 1'b1;
            phase_nxt = nrmc_pkg::PH_IDLE;
          end else begin
            ckhi_nxt  = hx.val;
            phase_nxt = nrmc_pkg::PH_CK2;
          end
        end
        nrmc_pkg::PH_CK2: begin
          emit      = 1'b1;
          sum_good  = hx.ok && ({ckhi_r, hx.val} == xor_r);
          phase_nxt = nrmc_pkg::PH_IDLE;
        end
        nrmc_pkg::PH_IDLE: begin
          phase_nxt = nrmc_pkg::PH_IDLE;
        end
        default: begin
          phase_nxt = nrmc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  assign flags.is_rmc   = hdr_ok_r && (hdr_idx_r == 3'(nrmc_pkg::HdrLen));
  assign flags.sum_good = sum_good;
  assign flags.fix_ok   = fix_r;

  nrmc_time_fmt u_fmt (
    .digits (digits_r),
    .zone   (zone_r),
    .flags  (flags),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      zone_r    <= nrmc_pkg::ZoneReset;
      phase_r   <= nrmc_pkg::PH_IDLE;
      hdr_idx_r <= 3'd0;
      hdr_ok_r  <= 1'b1;
      xor_r     <= 8'd0;
      comma_r   <= 4'd0;
      fidx_r    <= 3'd0;
      fix_r     <= 1'b0;
      digits_r  <= '0;
      ckhi_r    <= 4'd0;
    end else begin
      if (cfg_we) zone_r <= cfg_wdata;
      if (in_tready) in_vld_r <= in_tvalid;
      if (fire) begin
        phase_r   <= phase_nxt;
        hdr_idx_r <= hdr_idx_nxt;
        hdr_ok_r  <= hdr_ok_nxt;
        xor_r     <= xor_nxt;
        comma_r   <= comma_nxt;
        fidx_r    <= fidx_nxt;
        fix_r     <= fix_nxt;
        digits_r  <= digits_nxt;
        ckhi_r    <= ckhi_nxt;
        out_vld_r <= emit;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_char_r <= in_tdata;
    if (fire && emit) res_r <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, res_r.second, res_r.minute, res_r.hour, res_r.status};

endmodule

`default_nettype wire

// ----- sim/nmea_rmc_time_checker.sv -----
// Scoreboard for the NMEA RMC time extractor: watches the character, result and config
// channels, predicts each sentence result and compares it field by field.
// Depends on nrmc_pkg for widths, character codes, phase and status encodings.
module nmea_rmc_time_checker
  import nrmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [CharW-1:0]    in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [ZoneW-1:0]    cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  results_checked
);

  localparam int HourLsb = StatusW;
  localparam int MinLsb  = HourLsb + HourW;
  localparam int SecLsb  = MinLsb + MinW;
  localparam int PadLsb  = SecLsb + SecW;
  localparam logic [8*HdrLen-1:0] RmcTag = "GPRMC,";

  phase_t           scan_state;
  logic [2:0]       tag_pos;
  logic             tag_match;
  logic [7:0]       sum_acc;
  logic [3:0]       field_no;
  logic [2:0]       field_pos;
  logic             fix_seen;
  logic [3:0]       utc_digit [6];
  logic [3:0]       sum_hi;
  logic [ZoneW-1:0] zone_hours;
  result_t          sentence_results_due [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_checked);
    fail_count++;
  endtask

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
    return 5'h10;
  endfunction

  task automatic open_sentence();
    scan_state = PH_BODY;
    tag_pos    = '0;
    tag_match  = 1'b1;
    sum_acc    = '0;
    field_no   = '0;
    field_pos  = '0;
    fix_seen   = 1'b0;
    sum_hi     = '0;
    foreach (utc_digit[i]) utc_digit[i] = '0;
  endtask

  task automatic close_sentence(input logic sum_good);
    result_t r;
    int      h;
    int      m;
    int      s;
    r = '0;
    if (!(tag_match && tag_pos == HdrLen)) r.status = ST_NOTRMC;
    else if (!sum_good)                    r.status = ST_BADSUM;
    else if (!fix_seen)                    r.status = ST_NOFIX;
    else                                   r.status = ST_VALID;
    if (r.status == ST_VALID) begin
      h = utc_digit[0] * 10 + utc_digit[1] + zone_hours;
      m = utc_digit[2] * 10 + utc_digit[3];
      s = utc_digit[4] * 10 + utc_digit[5];
      r.hour   = HourW'(h % 24);
      r.minute = MinW'(m > 59 ? 59 : m);
      r.second = SecW'(s > 59 ? 59 : s);
    end
    sentence_results_due.push_back(r);
    scan_state = PH_IDLE;
  endtask

  task automatic take_body_char(input logic [7:0] c);
    sum_acc = sum_acc ^ c;
    if (tag_pos < HdrLen) begin
      if (c != RmcTag[8*(HdrLen-1-tag_pos) +: 8]) tag_match = 1'b0;
      tag_pos++;
    end
    if (c == ChComma) begin
      if (field_no != 4'd15) field_no++;
      field_pos = '0;
    end else begin
      if (field_no == 4'd1 && field_pos < 3'd6) begin
        utc_digit[field_pos] = (c >= "0" && c <= "9") ? 4'(c - "0") : 4'd0;
      end else if (field_no == 4'd2) begin
        fix_seen = (field_pos == 3'd0 && c == ChFixA);
      end
      if (field_pos != 3'd7) field_pos++;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [4:0] nib;
    nib = hex_nibble(c);
    if (c == ChDollar) begin
      open_sentence();
    end else begin
      case (scan_state)
        PH_BODY: begin
          if (c == ChStar) scan_state = PH_CK1;
          else take_body_char(c);
        end
        PH_CK1: begin
          if (nib[4]) begin
            close_sentence(1'b0);
          end else begin
            sum_hi     = nib[3:0];
            scan_state = PH_CK2;
          end
        end
        PH_CK2: begin
          if (nib[4]) close_sentence(1'b0);
          else close_sentence({sum_hi, nib[3:0]} == sum_acc);
        end
        default: scan_state = PH_IDLE;
      endcase
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      open_sentence();
      scan_state = PH_IDLE;
      zone_hours = ZoneReset;
      sentence_results_due.delete();
    end else begin
      if (cfg_we) zone_hours = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (sentence_results_due.size() == 0) begin
          report_mismatch("unexpected result", int'(out_tdata), 0);
        end else begin
          want = sentence_results_due.pop_front();
          if (out_tdata[0 +: StatusW] !== want.status)
            report_mismatch("sentence_status", out_tdata[0 +: StatusW], want.status);
          if (out_tdata[HourLsb +: HourW] !== want.hour)
            report_mismatch("local_hour", out_tdata[HourLsb +: HourW], want.hour);
          if (out_tdata[MinLsb +: MinW] !== want.minute)
            report_mismatch("minute_out", out_tdata[MinLsb +: MinW], want.minute);
          if (out_tdata[SecLsb +: SecW] !== want.second)
            report_mismatch("second_out", out_tdata[SecLsb +: SecW], want.second);
          if (out_tdata[OutDataW-1:PadLsb] !== '0)
            report_mismatch("padding", out_tdata[OutDataW-1:PadLsb], 0);
          results_checked++;
        end
      end
      if (in_tvalid && in_tready) parse_char(in_tdata);
    end
    pending = sentence_results_due.size();
  end

endmodule

// ----- sim/nmea_rmc_time_extractor_tb.sv -----
// Testbench top for nmea_rmc_time_extractor: builds NMEA sentence streams (directed
// corner cases, then random well-formed and broken sentences) under varying flow control.
// Depends on nrmc_pkg, the block under test and nmea_rmc_time_checker.
module nmea_rmc_time_extractor_tb;
  import nrmc_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 200;
  localparam int SettleCycles = 4;
  localparam int PhaseChars = 24;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [CharW-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_we;
  logic [ZoneW-1:0]    cfg_wdata;

  int fail_count;
  int pending;
  int results_checked;
  int chars_sent;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;

  logic [7:0] line_q [$];

  nmea_rmc_time_extractor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  nmea_rmc_time_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stall = 0;
      else stall++;
    end
    $display("watchdog: no transaction for %0d cycles", StallLimit);
    $display("nmea_rmc_time_extractor regression: fail");
    $finish;
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_zone(input logic [ZoneW-1:0] hours);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= hours;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 10) return "0" + nib;
    return 8'((lower ? "a" : "A") + nib - 10);
  endfunction

  function automatic logic [7:0] field_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ChDollar || b == ChStar);
    return b;
  endfunction

  task automatic close_with_checksum(input bit bad_sum, input bit lower);
    logic [7:0] sum;
    int         start;
    start = 0;
    foreach (line_q[i]) if (line_q[i] == ChDollar) start = i + 1;
    sum = '0;
    for (int i = start; i < line_q.size(); i++) sum ^= line_q[i];
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    line_q.push_back(ChStar);
    line_q.push_back(hex_char(sum[7:4], lower));
    line_q.push_back(hex_char(sum[3:0], lower));
  endtask

  task automatic make_rmc(input string utc, input string fix, input int extra,
                          input bit bad_sum, input bit lower);
    push_text("$GPRMC,");
    push_text(utc);
    push_text(",");
    push_text(fix);
    repeat (extra) begin
      line_q.push_back(ChComma);
      repeat ($urandom_range(0, 4)) line_q.push_back(field_byte());
    end
    close_with_checksum(bad_sum, lower);
  endtask

  function automatic string rand_utc();
    string s;
    s = $sformatf("%02d%02d%02d", $urandom_range(29), $urandom_range(70), $urandom_range(70));
    case ($urandom_range(9))
      0: s = s.substr(0, $urandom_range(0, 4));
      1: s = $sformatf("%s.%02d", s, $urandom_range(99));
      2: s = $sformatf("%s%c%s", s.substr(0, 2), 8'($urandom_range(33, 126)), s.substr(4, 5));
      3: s = $sformatf("%02d%02d%02d", $urandom_range(99), $urandom_range(99), $urandom_range(99));
      default: ;
    endcase
    return s;
  endfunction

  function automatic string rand_fix();
    case ($urandom_range(9))
      7:       return "V";
      8:       return "";
      9:       return "AA";
      default: return "A";
    endcase
  endfunction

  task automatic send_random_sentence();
    int         kind;
    int         cut;
    kind = $urandom_range(99);
    if (kind < 70) begin
      make_rmc(rand_utc(), rand_fix(), $urandom_range(0, 4), $urandom_range(9) == 0,
               1'($urandom_range(1)));
    end else if (kind < 76) begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(255)));
    end else if (kind < 82) begin
      push_text($sformatf("$GP%c%c%c,", 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                          8'($urandom_range(65, 90))));
      push_text(rand_utc());
      push_text(",A");
      close_with_checksum(1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (kind < 88) begin
      make_rmc(rand_utc(), rand_fix(), $urandom_range(0, 2), 1'b0, 1'b0);
      cut = $urandom_range(2, line_q.size() - 1);
      while (line_q.size() > cut) void'(line_q.pop_back());
    end else if (kind < 94) begin
      make_rmc(rand_utc(), "A", 0, 1'b0, 1'($urandom_range(1)));
      line_q[line_q.size() - 1 - $urandom_range(1)] = field_byte();
    end else begin
      push_text("$GPR");
      close_with_checksum(1'b0, 1'b0);
    end
    send_line();
  endtask

  initial begin
    int phase_chars;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    hold_req      = 1'b0;
    chars_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_text("junk\r\n");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    make_rmc("000000", "A", 0, 1'b0, 1'b0);
    make_rmc("235959", "A", 1, 1'b0, 1'b1);
    make_rmc("129999", "A", 0, 1'b0, 1'b0);
    make_rmc("12a4b6", "A", 0, 1'b0, 1'b0);
    make_rmc("12", "A", 0, 1'b0, 1'b0);
    make_rmc("1234567890", "A", 0, 1'b0, 1'b0);
    make_rmc("101010", "V", 0, 1'b0, 1'b0);
    make_rmc("101010", "", 0, 1'b0, 1'b0);
    make_rmc("101010", "AA", 0, 1'b0, 1'b0);
    make_rmc("101010", "A", 0, 1'b1, 1'b0);
    make_rmc("111111", "A", 18, 1'b0, 1'b0);
    make_rmc("202020", "A", 0, 1'b0, 1'b0);
    line_q[line_q.size() - 2] = "G";
    push_text("5");
    make_rmc("202020", "A", 0, 1'b0, 1'b1);
    line_q[line_q.size() - 1] = "g";
    push_text("$GPGGA,120000,A");
    close_with_checksum(1'b0, 1'b0);
    push_text("$GPR*00");
    push_text("$GPGGA,1*Z");
    push_text("$GPRMC,1234");
    make_rmc("0930", "A", 0, 1'b0, 1'b0);
    hold_req = 1'b1;
    send_line();

    write_zone(5'd31);
    make_rmc("235959", "A", 0, 1'b0, 1'b0);
    send_line();
    write_zone(5'd0);
    make_rmc("000000", "A", 0, 1'b0, 1'b0);
    send_line();
    write_zone(5'd23);
    make_rmc("010000", "A", 0, 1'b0, 1'b0);
    send_line();

    for (int p = 0; p < 3; p++) begin
      write_zone(p == 2 ? 5'd23 : 5'($urandom_range(31)));
      send_idle_pct = (p == 0) ? 38 : (p == 1) ? 57 : 0;
      recv_idle_pct = (p == 0) ? 57 : (p == 1) ? 38 : 0;
      phase_chars   = chars_sent;
      while (chars_sent - phase_chars < PhaseChars) send_random_sentence();
    end
    settle();

    $display("covered %0d characters and %0d sentence results over three flow-control phases,",
             chars_sent, results_checked);
    $display("zone offsets 0, 8, 23, 31 and random, with directed header, checksum and time cases");
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("nmea_rmc_time_extractor regression: pass");
    end else begin
      $display("nmea_rmc_time_extractor regression: fail");
    end
    $finish;
  end

endmodule

// ----- nmea_rmc_time_extractor.f -----
hw/rtl/nrmc_pkg.sv
hw/rtl/nrmc_time_fmt.sv
hw/rtl/nmea_rmc_time_extractor.sv
sim/nmea_rmc_time_checker.sv
sim/nmea_rmc_time_extractor_tb.sv
